@@ rtl/core/pscp_pkg.sv @@
// Shared constants, codes and control types for the pendulum swing-up controller.
package pscp_pkg;

  localparam int WINDOW_HALF_DEF  = 600;
  localparam int CHECK_PERIOD_DEF = 40;
  localparam int POS_PERIOD_DEF   = 50;
  localparam int ANG_PERIOD_DEF   = 5;

  localparam logic [2:0] MODE_STOP  = 3'd0;
  localparam logic [2:0] MODE_KICK  = 3'd1;
  localparam logic [2:0] MODE_BAL   = 3'd2;
  localparam logic [2:0] MODE_LEFT  = 3'd3;
  localparam logic [2:0] MODE_RIGHT = 3'd4;

  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  localparam logic [2:0] REG_POS_KP   = 3'd0;
  localparam logic [2:0] REG_POS_KI   = 3'd1;
  localparam logic [2:0] REG_POS_KD   = 3'd2;
  localparam logic [2:0] REG_POS_TGT  = 3'd3;
  localparam logic [2:0] REG_ANG_KP   = 3'd4;
  localparam logic [2:0] REG_ANG_KI   = 3'd5;
  localparam logic [2:0] REG_ANG_KD   = 3'd6;
  localparam logic [2:0] REG_UPRIGHT  = 3'd7;

  localparam logic signed [7:0] DRIVE_PULSE = 8'sd50;
  localparam logic signed [7:0] DRIVE_LIMIT = 8'sd100;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FRONT,
    OP_ERR,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_SUM,
    OP_FIN,
    OP_PUB
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ang;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_go;
    logic ang_go;
  } dp_stat_t;

endpackage

@@ rtl/core/pscp_ctrl.sv @@
// Sequencer for one tick: front update, PID loop steps and result transfer.
module pscp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output pscp_pkg::dp_cmd_t  cmd_o,
  input  pscp_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_FRONT, S_ERR, S_MP, S_MI, S_MD, S_SUM, S_FIN, S_PUB
  } state_t;

  state_t state;
  logic   ang_sel;
  logic   ang_pend;
  logic   pub_ok;

  assign in_stall = (state != S_IDLE);
  assign pub_ok   = !out_valid || !out_stall;

  always_comb begin
    cmd_o.ang = ang_sel;
    unique case (state)
      S_IDLE:  cmd_o.op = (in_valid) ? pscp_pkg::OP_LOAD : pscp_pkg::OP_NONE;
      S_FRONT: cmd_o.op = pscp_pkg::OP_FRONT;
      S_ERR:   cmd_o.op = pscp_pkg::OP_ERR;
      S_MP:    cmd_o.op = pscp_pkg::OP_MUL_P;
      S_MI:    cmd_o.op = pscp_pkg::OP_MUL_I;
      S_MD:    cmd_o.op = pscp_pkg::OP_MUL_D;
      S_SUM:   cmd_o.op = pscp_pkg::OP_SUM;
      S_FIN:   cmd_o.op = pscp_pkg::OP_FIN;
      S_PUB:   cmd_o.op = (pub_ok) ? pscp_pkg::OP_PUB : pscp_pkg::OP_NONE;
      default: cmd_o.op = pscp_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ang_sel   <= 1'b0;
      ang_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !(state == S_PUB)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_FRONT;
        S_FRONT: begin
          ang_pend <= stat.ang_go;
          priority if (stat.pos_go) begin
            ang_sel <= 1'b0;
            state   <= S_ERR;
          end else if (stat.ang_go) begin
            ang_sel <= 1'b1;
            state   <= S_ERR;
          end else begin
            state <= S_PUB;
          end
        end
        S_ERR: state <= S_MP;
        S_MP:  state <= S_MI;
        S_MI:  state <= S_MD;
        S_MD:  state <= S_SUM;
        S_SUM: state <= S_FIN;
        S_FIN: begin
          if (!ang_sel && ang_pend) begin
            ang_sel <= 1'b1;
            state   <= S_ERR;
          end else begin
            state <= S_PUB;
          end
        end
        S_PUB: begin
          if (pub_ok) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/pscp_dp.sv @@
// Datapath: registers, mode logic, shared gain multiplier and result register.
module pscp_dp #(
  parameter int WINDOW_HALF  = pscp_pkg::WINDOW_HALF_DEF,
  parameter int CHECK_PERIOD = pscp_pkg::CHECK_PERIOD_DEF,
  parameter int POS_PERIOD   = pscp_pkg::POS_PERIOD_DEF,
  parameter int ANG_PERIOD   = pscp_pkg::ANG_PERIOD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_addr,
  input  logic [15:0]         cfg_wdata,
  input  logic [11:0]         angle_sample,
  input  logic signed [15:0]  encoder_delta,
  input  logic [1:0]          cmd,
  output logic signed [7:0]   motor_drive,
  output logic                led_on,
  output logic [2:0]          mode,
  input  pscp_pkg::dp_cmd_t   cmd_i,
  output pscp_pkg::dp_stat_t  stat
);

  localparam int CW = $clog2(CHECK_PERIOD + 1);
  localparam int PW = $clog2(POS_PERIOD + 1);
  localparam int AW = $clog2(ANG_PERIOD + 1);
  localparam logic [CW-1:0] CHK_P = CW'(CHECK_PERIOD);
  localparam logic [PW-1:0] POS_P = PW'(POS_PERIOD);
  localparam logic [AW-1:0] ANG_P = AW'(ANG_PERIOD);
  localparam logic signed [13:0] WH       = 14'(WINDOW_HALF);
  localparam logic signed [13:0] SW_LOW   = 14'sd200;
  localparam logic signed [13:0] SW_HIGH  = 14'sd3895;
  localparam logic signed [49:0] POS_LIM  = 50'sd204800;
  localparam logic signed [49:0] ANG_LIM  = 50'sd1677721600;
  localparam logic signed [31:0] Q24_RND  = 32'sd16777215;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r = v[31:0];
    return r;
  endfunction

  logic [15:0] pos_kp, pos_ki, pos_kd, pos_tgt, ang_kp, ang_ki, ang_kd;
  logic [11:0] upright;

  logic [11:0]        in_a;
  logic signed [15:0] in_d;
  logic [1:0]         in_cmd;

  logic [2:0]         mode_reg;
  logic               armed;
  logic               led_reg;
  logic signed [7:0]  drive_reg;
  logic [CW-1:0]      check_counter;
  logic [PW-1:0]      pos_counter;
  logic [AW-1:0]      ang_counter;
  logic [11:0]        h0, h1, h2;
  logic [15:0]        encoder_sum;
  logic signed [17:0] pos_prev_error;
  logic signed [31:0] pos_integral;
  logic signed [25:0] angle_setpoint;
  logic signed [25:0] ang_prev_error;
  logic signed [31:0] ang_integral;

  logic signed [31:0] w_e, w_de;
  logic signed [48:0] prod;
  logic signed [49:0] acc;

  logic [2:0]         mode_next, mode_sel;
  logic               armed_next, led_next;
  logic signed [7:0]  drive_next;
  logic [CW-1:0]      cc_next;
  logic [PW-1:0]      pc_next;
  logic [AW-1:0]      ac_next;
  logic [11:0]        h0_next, h1_next, h2_next;
  logic signed [13:0] sa, lo, hi;

  logic signed [17:0] pe;
  logic signed [25:0] ae;
  logic [15:0]        g_p, g_i, g_d;
  logic signed [31:0] integ;
  logic signed [48:0] mul_out;
  logic signed [31:0] mul_opnd;
  logic [15:0]        mul_gain;
  logic signed [49:0] u_c;
  logic signed [31:0] u_a;
  logic signed [31:0] u_q;

  assign sa = $signed({2'b00, in_a});
  assign lo = $signed({2'b00, upright}) - WH;
  assign hi = $signed({2'b00, upright}) + WH;

  always_comb begin
    mode_next  = mode_reg;
    armed_next = armed;
    led_next   = led_reg;
    drive_next = drive_reg;
    cc_next    = check_counter + 1'b1;
    pc_next    = pos_counter;
    ac_next    = ang_counter;
    h0_next    = h0;
    h1_next    = h1;
    h2_next    = h2;
    stat       = '0;
    if (in_cmd == pscp_pkg::CMD_START) begin
      mode_next  = pscp_pkg::MODE_KICK;
      armed_next = 1'b1;
    end else if (in_cmd == pscp_pkg::CMD_STOP) begin
      mode_next  = pscp_pkg::MODE_STOP;
      armed_next = 1'b0;
    end
    if (cc_next >= CHK_P) begin
      cc_next = '0;
      h2_next = h1;
      h1_next = h0;
      h0_next = in_a;
      if (mode_next != pscp_pkg::MODE_BAL && armed_next) begin
        if (sa <= lo && sa >= SW_LOW) mode_next = pscp_pkg::MODE_LEFT;
        if (sa <= SW_HIGH && sa >= hi) mode_next = pscp_pkg::MODE_RIGHT;
      end
      if (armed_next && sa >= lo && sa <= hi) mode_next = pscp_pkg::MODE_BAL;
    end
    mode_sel = mode_next;
    case (mode_sel)
      pscp_pkg::MODE_STOP: begin
        led_next   = 1'b0;
        armed_next = 1'b0;
        drive_next = '0;
      end
      pscp_pkg::MODE_KICK: begin
        led_next   = 1'b1;
        drive_next = -pscp_pkg::DRIVE_PULSE;
      end
      pscp_pkg::MODE_LEFT: begin
        if (h1_next > h0_next && h1_next > h2_next) drive_next = pscp_pkg::DRIVE_PULSE;
      end
      pscp_pkg::MODE_RIGHT: begin
        if (h1_next < h0_next && h1_next < h2_next) drive_next = -pscp_pkg::DRIVE_PULSE;
      end
      pscp_pkg::MODE_BAL: begin
        pc_next = pos_counter + 1'b1;
        ac_next = ang_counter + 1'b1;
        if (!(sa > lo && sa < hi)) mode_next = pscp_pkg::MODE_STOP;
        if (pc_next >= POS_P) begin
          pc_next     = '0;
          stat.pos_go = 1'b1;
        end
        if (ac_next >= ANG_P) begin
          ac_next     = '0;
          stat.ang_go = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pe    = $signed({2'b00, pos_tgt}) - $signed({2'b00, encoder_sum});
  assign ae    = angle_setpoint - $signed({2'b00, in_a, 12'h000});
  assign g_p   = cmd_i.ang ? ang_kp : pos_kp;
  assign g_i   = cmd_i.ang ? ang_ki : pos_ki;
  assign g_d   = cmd_i.ang ? ang_kd : pos_kd;
  assign integ = cmd_i.ang ? ang_integral : pos_integral;

  always_comb begin
    unique case (cmd_i.op)
      pscp_pkg::OP_MUL_I: begin
        mul_gain = g_i;
        mul_opnd = integ;
      end
      pscp_pkg::OP_MUL_D: begin
        mul_gain = g_d;
        mul_opnd = w_de;
      end
      default: begin
        mul_gain = g_p;
        mul_opnd = w_e;
      end
    endcase
  end

  assign mul_out = $signed({1'b0, mul_gain}) * mul_opnd;

  always_comb begin
    u_c = acc;
    if (cmd_i.ang) begin
      if (acc > ANG_LIM) u_c = ANG_LIM;
      else if (acc < -ANG_LIM) u_c = -ANG_LIM;
    end else begin
      if (acc > POS_LIM) u_c = POS_LIM;
      else if (acc < -POS_LIM) u_c = -POS_LIM;
    end
    u_a = u_c[31:0];
    u_q = u_a[31] ? ((u_a + Q24_RND) >>> 24) : (u_a >>> 24);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_kp         <= 16'd2458;
      pos_ki         <= 16'd0;
      pos_kd         <= 16'd16384;
      pos_tgt        <= 16'd0;
      ang_kp         <= 16'd1229;
      ang_ki         <= 16'd41;
      ang_kd         <= 16'd2458;
      upright        <= 12'd2085;
      mode_reg       <= pscp_pkg::MODE_STOP;
      armed          <= 1'b0;
      led_reg        <= 1'b0;
      drive_reg      <= '0;
      check_counter  <= '0;
      pos_counter    <= '0;
      ang_counter    <= '0;
      h0             <= '0;
      h1             <= '0;
      h2             <= '0;
      encoder_sum    <= '0;
      pos_prev_error <= '0;
      pos_integral   <= '0;
      angle_setpoint <= '0;
      ang_prev_error <= '0;
      ang_integral   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          pscp_pkg::REG_POS_KP:  pos_kp  <= cfg_wdata;
          pscp_pkg::REG_POS_KI:  pos_ki  <= cfg_wdata;
          pscp_pkg::REG_POS_KD:  pos_kd  <= cfg_wdata;
          pscp_pkg::REG_POS_TGT: pos_tgt <= cfg_wdata;
          pscp_pkg::REG_ANG_KP:  ang_kp  <= cfg_wdata;
          pscp_pkg::REG_ANG_KI:  ang_ki  <= cfg_wdata;
          pscp_pkg::REG_ANG_KD:  ang_kd  <= cfg_wdata;
          pscp_pkg::REG_UPRIGHT: upright <= cfg_wdata[11:0];
        endcase
      end
      unique case (cmd_i.op)
        pscp_pkg::OP_FRONT: begin
          mode_reg      <= mode_next;
          armed         <= armed_next;
          led_reg       <= led_next;
          drive_reg     <= drive_next;
          check_counter <= cc_next;
          pos_counter   <= pc_next;
          ang_counter   <= ac_next;
          h0            <= h0_next;
          h1            <= h1_next;
          h2            <= h2_next;
          encoder_sum   <= encoder_sum + $unsigned(in_d);
        end
        pscp_pkg::OP_ERR: begin
          if (cmd_i.ang) begin
            ang_prev_error <= ae;
            if (ang_ki == '0) ang_integral <= '0;
            else ang_integral <= sat32(33'(ang_integral) + 33'(ae));
          end else begin
            pos_prev_error <= pe;
            if (pos_ki == '0) pos_integral <= '0;
            else pos_integral <= sat32(33'(pos_integral) + 33'(pe));
          end
        end
        pscp_pkg::OP_FIN: begin
          if (cmd_i.ang) drive_reg <= u_q[7:0];
          else angle_setpoint <= $signed({2'b00, upright, 12'h000}) - u_c[25:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.op == pscp_pkg::OP_LOAD) begin
      in_a   <= angle_sample;
      in_d   <= encoder_delta;
      in_cmd <= cmd;
    end
    if (cmd_i.op == pscp_pkg::OP_ERR) begin
      if (cmd_i.ang) begin
        w_e  <= 32'(ae);
        w_de <= 32'(27'(ae) - 27'(ang_prev_error));
      end else begin
        w_e  <= 32'(pe);
        w_de <= 32'(19'(pe) - 19'(pos_prev_error));
      end
    end
    if (cmd_i.op == pscp_pkg::OP_MUL_P || cmd_i.op == pscp_pkg::OP_MUL_I ||
        cmd_i.op == pscp_pkg::OP_MUL_D) begin
      prod <= mul_out;
    end
    if (cmd_i.op == pscp_pkg::OP_MUL_I) acc <= 50'(prod);
    if (cmd_i.op == pscp_pkg::OP_MUL_D || cmd_i.op == pscp_pkg::OP_SUM) begin
      acc <= acc + 50'(prod);
    end
    if (cmd_i.op == pscp_pkg::OP_PUB) begin
      motor_drive <= drive_reg;
      led_on      <= led_reg;
      mode        <= mode_reg;
    end
  end

endmodule

@@ rtl/core/pendulum_swingup_cascade_pid.sv @@
// Top level of the inverted pendulum swing-up and cascaded PID balance controller.
// One input transfer per timer tick yields one result transfer. A tick steps from
// acceptance to result through load, mode update and result register; each PID loop
// that fires in that tick adds error, P, I and D product, sum and finish steps on the
// single shared 16x32 gain multiplier, the position loop before the angle loop. The next
// tick is accepted once the result is registered, even while that result is still stalled.
// Gains are unsigned Q4.12; write configuration only while the block is idle.
module pendulum_swingup_cascade_pid #(
  parameter int WINDOW_HALF  = pscp_pkg::WINDOW_HALF_DEF,
  parameter int CHECK_PERIOD = pscp_pkg::CHECK_PERIOD_DEF,
  parameter int POS_PERIOD   = pscp_pkg::POS_PERIOD_DEF,
  parameter int ANG_PERIOD   = pscp_pkg::ANG_PERIOD_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        angle_sample,
  input  logic signed [15:0] encoder_delta,
  input  logic [1:0]         cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  motor_drive,
  output logic               led_on,
  output logic [2:0]         mode
);

  pscp_pkg::dp_cmd_t  dp_cmd;
  pscp_pkg::dp_stat_t dp_stat;

  pscp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (dp_cmd),
    .stat      (dp_stat)
  );

  pscp_dp #(
    .WINDOW_HALF  (WINDOW_HALF),
    .CHECK_PERIOD (CHECK_PERIOD),
    .POS_PERIOD   (POS_PERIOD),
    .ANG_PERIOD   (ANG_PERIOD)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .angle_sample  (angle_sample),
    .encoder_delta (encoder_delta),
    .cmd           (cmd),
    .motor_drive   (motor_drive),
    .led_on        (led_on),
    .mode          (mode),
    .cmd_i         (dp_cmd),
    .stat          (dp_stat)
  );

endmodule

@@ rtl/core/pscp_checker.sv @@
// Port-level checks for the pendulum controller, bound to the top level.
module pscp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [7:0] motor_drive,
  input logic              led_on,
  input logic [2:0]        mode
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken during tick processing");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_drive <= pscp_pkg::DRIVE_LIMIT &&
                   motor_drive >= -pscp_pkg::DRIVE_LIMIT))
    else $error("motor drive out of range");

  a_kick_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == pscp_pkg::MODE_KICK |->
      motor_drive == -pscp_pkg::DRIVE_PULSE && led_on)
    else $error("kick mode without kick pulse and lamp");

endmodule

bind pendulum_swingup_cascade_pid pscp_checker u_pscp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .motor_drive (motor_drive),
  .led_on      (led_on),
  .mode        (mode)
);

@@ tb/sv/pendulum_swingup_cascade_pid_tb.sv @@
// Self-checking testbench for the pendulum swing-up and cascaded PID controller.
module pendulum_swingup_cascade_pid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SWING_LO  = 200;
  localparam int  SWING_HI  = 3895;
  localparam int  WATCHDOG  = 3000;
  localparam int  DRAIN     = 20;
  localparam longint POS_LIM = 50 * 4096;
  localparam longint ANG_LIM = 100 * 64'sd16777216;

  typedef struct {
    logic [11:0]        angle;
    logic signed [15:0] delta;
    logic [1:0]         cmd;
  } tick_in_t;

  typedef struct {
    logic signed [7:0] drive;
    logic              led;
    logic [2:0]        mode;
  } tick_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_addr = '0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [11:0]        angle_sample = '0;
  logic signed [15:0] encoder_delta = '0;
  logic [1:0]         cmd = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [7:0]  motor_drive;
  logic               led_on;
  logic [2:0]         mode;

  pendulum_swingup_cascade_pid dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tick_in_t  tick_stim_q[$];
  tick_out_t tick_results_q[$];
  int  errors = 0;
  bit  idling = 1'b1;
  int  quiet_cycles = 0;

  // controller shadow state
  longint      gain_q[8];
  logic [2:0]  md;
  logic        armed, led;
  logic [11:0] hist[3];
  int          chk_cnt, pos_cnt, ang_cnt;
  logic [15:0] enc_sum;
  longint      pos_prev, pos_int, ang_set, ang_prev, ang_int;
  logic signed [7:0] drive;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clampv(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void pendulum_tick(tick_in_t t);
    longint sa, up, lo, hi, e, u;
    tick_out_t r;
    sa = t.angle;
    up = gain_q[pscp_pkg::REG_UPRIGHT];
    lo = up - pscp_pkg::WINDOW_HALF_DEF;
    hi = up + pscp_pkg::WINDOW_HALF_DEF;
    if (t.cmd == pscp_pkg::CMD_START) begin
      md = pscp_pkg::MODE_KICK; armed = 1'b1;
    end else if (t.cmd == pscp_pkg::CMD_STOP) begin
      md = pscp_pkg::MODE_STOP; armed = 1'b0;
    end
    enc_sum = enc_sum + t.delta;
    chk_cnt++;
    if (chk_cnt >= pscp_pkg::CHECK_PERIOD_DEF) begin
      chk_cnt = 0;
      hist[2] = hist[1]; hist[1] = hist[0]; hist[0] = t.angle;
      if (md != pscp_pkg::MODE_BAL && armed) begin
        if (sa <= lo && sa >= SWING_LO) md = pscp_pkg::MODE_LEFT;
        if (sa <= SWING_HI && sa >= hi) md = pscp_pkg::MODE_RIGHT;
      end
      if (armed && sa >= lo && sa <= hi) md = pscp_pkg::MODE_BAL;
    end
    case (md)
      pscp_pkg::MODE_STOP: begin
        led = 1'b0; armed = 1'b0; drive = '0;
      end
      pscp_pkg::MODE_KICK: begin
        led = 1'b1; drive = -pscp_pkg::DRIVE_PULSE;
      end
      pscp_pkg::MODE_LEFT: begin
        if (hist[1] > hist[0] && hist[1] > hist[2]) drive = pscp_pkg::DRIVE_PULSE;
      end
      pscp_pkg::MODE_RIGHT: begin
        if (hist[1] < hist[0] && hist[1] < hist[2]) drive = -pscp_pkg::DRIVE_PULSE;
      end
      pscp_pkg::MODE_BAL: begin
        pos_cnt++;
        ang_cnt++;
        if (!(sa > lo && sa < hi)) md = pscp_pkg::MODE_STOP;
        if (pos_cnt >= pscp_pkg::POS_PERIOD_DEF) begin
          pos_cnt = 0;
          e = gain_q[pscp_pkg::REG_POS_TGT] - longint'(enc_sum);
          pos_int = (gain_q[pscp_pkg::REG_POS_KI] == 0) ? 0 : sat32(pos_int + e);
          u = gain_q[pscp_pkg::REG_POS_KP] * e + gain_q[pscp_pkg::REG_POS_KI] * pos_int
              + gain_q[pscp_pkg::REG_POS_KD] * (e - pos_prev);
          pos_prev = e;
          ang_set = up * 4096 - clampv(u, POS_LIM);
        end
        if (ang_cnt >= pscp_pkg::ANG_PERIOD_DEF) begin
          ang_cnt = 0;
          e = ang_set - sa * 4096;
          ang_int = (gain_q[pscp_pkg::REG_ANG_KI] == 0) ? 0 : sat32(ang_int + e);
          u = gain_q[pscp_pkg::REG_ANG_KP] * e + gain_q[pscp_pkg::REG_ANG_KI] * ang_int
              + gain_q[pscp_pkg::REG_ANG_KD] * (e - ang_prev);
          ang_prev = e;
          drive = 8'(clampv(u, ANG_LIM) / 64'sd16777216);
        end
      end
      default: ;
    endcase
    r.drive = drive; r.led = led; r.mode = md;
    tick_results_q.push_back(r);
  endfunction

  // input driver
  int in_gap = 0;
  always @(posedge clk) begin
    tick_in_t t;
    logic nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        t.angle = angle_sample; t.delta = encoder_delta; t.cmd = cmd;
        pendulum_tick(t);
      end
      if (!(in_valid && in_stall)) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (tick_stim_q.size() > 0) begin
          t = tick_stim_q.pop_front();
          angle_sample <= t.angle;
          encoder_delta <= t.delta;
          cmd <= t.cmd;
          nv = 1'b1;
          if (idling && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 12);
        end
        in_valid <= nv;
      end
    end
  end

  // output monitor
  int stall_left = 0;
  always @(posedge clk) begin
    tick_out_t x;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tick_results_q.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          x = tick_results_q.pop_front();
          if (motor_drive !== x.drive) begin
            $error("motor_drive expected %0d actual %0d", x.drive, motor_drive);
            errors++;
          end
          if (led_on !== x.led) begin
            $error("led_on expected %0d actual %0d", x.led, led_on);
            errors++;
          end
          if (mode !== x.mode) begin
            $error("mode expected %0d actual %0d", x.mode, mode);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("pendulum_swingup_cascade_pid_tb NOT OK");
      $finish;
    end
  end

  task automatic push_tick(int a, int d, int c);
    tick_in_t t;
    t.angle = 12'(a); t.delta = 16'(d); t.cmd = 2'(c);
    tick_stim_q.push_back(t);
  endtask

  function automatic int near_upright(int spread);
    int a;
    a = int'(gain_q[pscp_pkg::REG_UPRIGHT]) + $urandom_range(0, 2 * spread) - spread;
    if (a < 0) a = 0;
    if (a > 4095) a = 4095;
    return a;
  endfunction

  task automatic balance_run(int n);
    push_tick(near_upright(590), $urandom_range(0, 40) - 20, pscp_pkg::CMD_START);
    repeat (n) begin
      if ($urandom_range(0, 60) == 0) push_tick($urandom_range(0, 4095), 0, 0);
      else push_tick(near_upright(590), $urandom_range(0, 400) - 200, 0);
    end
  endtask

  task automatic swing_run(int n);
    push_tick($urandom_range(0, 4095), $urandom(), pscp_pkg::CMD_START);
    repeat (n) begin
      if ($urandom_range(0, 1)) push_tick($urandom_range(SWING_LO, 1500), $urandom(), 0);
      else push_tick($urandom_range(2600, SWING_HI), $urandom(), 0);
    end
  endtask

  task automatic random_part(int n);
    int k;
    while (n > 0) begin
      k = $urandom_range(0, 9);
      if (k < 5) begin
        balance_run(60 + $urandom_range(0, 80)); n -= 100;
      end else if (k < 8) begin
        swing_run(120); n -= 120;
      end else begin
        repeat (20) push_tick($urandom_range(0, 4095), $urandom(), $urandom_range(0, 3));
        n -= 20;
      end
    end
  endtask

  task automatic wait_idle();
    while (tick_stim_q.size() > 0 || in_valid || tick_results_q.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_gains(longint v[8]);
    for (int i = 0; i < 8; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= 3'(i);
      cfg_wdata <= 16'(v[i]);
      gain_q[i] = (i == pscp_pkg::REG_UPRIGHT) ? (v[i] & 12'hFFF) : (v[i] & 16'hFFFF);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    longint v[8];
    gain_q = '{2458, 0, 16384, 0, 1229, 41, 2458, 2085};
    md = pscp_pkg::MODE_STOP; armed = 0; led = 0; hist = '{0, 0, 0};
    chk_cnt = 0; pos_cnt = 0; ang_cnt = 0; enc_sum = '0;
    pos_prev = 0; pos_int = 0; ang_set = 0; ang_prev = 0; ang_int = 0; drive = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    v = '{3000, 200, 8000, 100, 2000, 60, 3000, 2085};
    write_gains(v);
    push_tick(0, -32768, 0);
    push_tick(4095, 32767, 3);
    push_tick(2085, 0, pscp_pkg::CMD_START);
    push_tick(2085, 1, pscp_pkg::CMD_STOP);
    push_tick(2085, -1, pscp_pkg::CMD_START);
    repeat (38) push_tick(2085, 5, 0);
    repeat (12) push_tick(2085 + 599, 7, 0);
    push_tick(2085 + 600, 0, 0);
    push_tick(100, 0, 0);
    random_part(150);
    wait_idle();

    v = '{65535, 65535, 65535, 65535, 65535, 65535, 65535, 4095};
    write_gains(v);
    push_tick(4095, 32767, pscp_pkg::CMD_START);
    repeat (60) push_tick(4095 - $urandom_range(0, 3), 32767, 0);
    random_part(150);
    wait_idle();

    v = '{0, 0, 0, 0, 0, 0, 0, 0};
    write_gains(v);
    random_part(150);
    wait_idle();

    for (int i = 0; i < 8; i++) v[i] = $urandom_range(0, 65535);
    v[pscp_pkg::REG_UPRIGHT] = $urandom_range(700, 3300);
    v[pscp_pkg::REG_POS_KI] = $urandom_range(0, 1) ? 0 : v[pscp_pkg::REG_POS_KI];
    write_gains(v);
    random_part(150);
    wait_idle();

    v = '{2458, 0, 16384, 0, 1229, 41, 2458, 2085};
    write_gains(v);
    idling = 1'b0;
    random_part(150);
    wait_idle();

    if (errors == 0) $display("pendulum_swingup_cascade_pid_tb OK");
    else $display("pendulum_swingup_cascade_pid_tb NOT OK");
    $finish;
  end
endmodule
